// ----- rtl/core/dbbe_pkg.sv -----
// ----------------------------------------------------------------------------
// dbbe_pkg
// Shared types, codes and constants of the delay based backoff estimator.
// ----------------------------------------------------------------------------
package dbbe_pkg;

  // item kinds carried in the input tuser
  typedef enum logic [1:0] {
    KIND_ACK   = 2'd0,
    KIND_LOSS  = 2'd1,
    KIND_QUERY = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_WIN_FLOOR = 2'd0,
    CFG_INIT_INV  = 2'd1,
    CFG_BASE_INV  = 2'd2,
    CFG_UNUSED    = 2'd3
  } cfg_idx_t;

  // sequencer states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ACK,
    ST_LOSS,
    ST_ROUND,
    ST_AVG,
    ST_AVG_WAIT,
    ST_RDIV,
    ST_RDIV_WAIT,
    ST_PMUL,
    ST_LOMUL,
    ST_HIMUL,
    ST_LOG,
    ST_THRESH,
    ST_D2,
    ST_D3,
    ST_CMP,
    ST_NUM,
    ST_CLOSE,
    ST_QMUL,
    ST_QDIV,
    ST_QDIV_WAIT,
    ST_QRED,
    ST_DONE
  } state_t;

  // divider status back to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  localparam int DIVIDEND_W = 64;
  localparam int DIVISOR_W  = 40;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

  localparam int IN_DATA_W  = 216;
  localparam int OUT_DATA_W = 48;

  localparam logic [5:0]  BETA_LO     = 6'd8;
  localparam logic [5:0]  BETA_HI     = 6'd32;
  localparam logic [15:0] RECIP_TEN   = 16'd6554;
  localparam logic [15:0] RECIP_TEN8  = 16'd52432;
  localparam logic [13:0] RECIP_SEVEN = 14'd9363;
  localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;
  localparam logic [7:0]  WIN_FLOOR_RST = 8'd15;
  localparam logic [6:0]  INIT_INV_RST  = 7'd80;
  localparam logic [6:0]  BASE_INV_RST  = 7'd88;

  // inverse beta, floored at zero
  function automatic logic [6:0] inv_of(input logic [6:0] base, input logic [5:0] beta);
    logic [6:0] b7;
    b7 = {1'b0, beta};
    return (base > b7) ? (base - b7) : 7'd0;
  endfunction

endpackage

// ----- rtl/core/dbbe_divider.sv -----
// ----------------------------------------------------------------------------
// dbbe_divider
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dbbe_divider (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic [dbbe_pkg::DIVIDEND_W-1:0]        dividend,
  input  logic [dbbe_pkg::DIVISOR_W-1:0]         divisor,
  output logic [dbbe_pkg::DIVIDEND_W-1:0]        quotient,
  output dbbe_pkg::div_stat_t                    stat
);
  import dbbe_pkg::*;

  logic                  busy;
  logic                  done;
  logic [DIV_CNT_W-1:0]  cnt;
  logic [DIVISOR_W:0]    rem;
  logic [DIVIDEND_W-1:0] dvd;
  logic [DIVISOR_W-1:0]  dvs;
  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W:0]    rem_sh;
  logic                  ge;

  assign rem_sh = {rem[DIVISOR_W-1:0], dvd[DIVIDEND_W-1]};
  assign ge     = (rem_sh >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIVIDEND_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvd <= dividend;
      dvs <= divisor;
      quo <= '0;
    end else if (busy) begin
      rem <= ge ? (rem_sh - {1'b0, dvs}) : rem_sh;
      dvd <= {dvd[DIVIDEND_W-2:0], 1'b0};
      quo <= {quo[DIVIDEND_W-2:0], ge};
    end
  end

  assign quotient  = quo;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ----- rtl/core/delay_based_backoff_estimator_core.sv -----
// ----------------------------------------------------------------------------
// delay_based_backoff_estimator_core
// Per-ack backoff estimator: rtt averaging, round tracking, beta and ssthresh.
// ----------------------------------------------------------------------------
//  channel   | dir | words / signals
//  s_axis    | in  | one item per word, kind in tuser, fields in tdata
//  m_axis    | out | one result per item, round_ended in tlast
//  cfg       | in  | cfg_we, cfg_index, cfg_data, no read-back
//
//  kind 3: straight to done, loss: loss state, ack without round end: ack and round states
//  ssthresh query: averaging, multiply, divide and reduce steps (none, one or two divider waits)
//  ack closing a round: two divides on the shared divider, then the multiply
//  steps on the one shared multiplier and the log2 search
//  reset is synchronous, all estimator state returns to its reset values
//  a finished result waits in the output register; the next item is taken
//  while it waits, and only the final load stalls on a full output register
// ----------------------------------------------------------------------------
module delay_based_backoff_estimator_core (
  input  logic                             clk,
  input  logic                             rst,
  // s_axis_tdata: rtt_sample[31:0], ack_delayed[32], slow_start[33],
  // interval_valid[34], sent_count[66:35], delivered_now[98:67],
  // smoothed_rtt[130:99], cwnd[162:131], seg_size[178:163],
  // max_bw[210:179], zero pad to 216
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [dbbe_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // s_axis_tuser: kind[1:0]
  input  logic [1:0]                       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // m_axis_tdata: beta_now[5:0], inverse_beta_now[12:6],
  // slow_start_threshold[44:13], zero pad to 48
  output logic [dbbe_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // round_ended
  output logic                             m_axis_tlast,
  input  logic                             cfg_we,
  input  logic [1:0]                       cfg_index,
  input  logic [7:0]                       cfg_data
);
  import dbbe_pkg::*;

  state_t state, state_next;

  // configuration
  logic [7:0] win_floor;
  logic [6:0] init_inv;
  logic [6:0] base_inv;

  // estimator state
  logic [63:0] rtt_sum;
  logic [31:0] rtt_count;
  logic [31:0] last_sample;
  logic [31:0] round_min_rtt;
  logic [31:0] round_max_rtt;
  logic [31:0] min_rtt;
  logic [31:0] max_rtt;
  logic [31:0] current_rtt;
  logic [5:0]  beta_reg;
  logic [6:0]  inverse_beta_reg;
  logic [31:0] next_round_mark;

  // latched item
  kind_t       in_kind;
  logic [31:0] in_rtt;
  logic        in_delayed;
  logic        in_ss;
  logic        in_ivalid;
  logic [31:0] in_prior;
  logic [31:0] in_deliv;
  logic [31:0] in_srtt;
  logic [31:0] in_cwnd;
  logic [15:0] in_seg;
  logic [31:0] in_bw;

  // working registers
  logic [31:0] da;
  logic [16:0] recip_seg;
  logic [63:0] bw_delay;
  logic [48:0] lo_part;
  logic [80:0] lg_val;
  logic [6:0]  lg;
  logic [2:0]  lg_step;
  logic [31:0] d2;
  logic [31:0] d3;
  logic [37:0] num;
  logic [38:0] q_div;
  logic [31:0] q_sat;
  logic [31:0] ssth;
  logic        ended;

  // output register
  logic        out_valid;
  logic [5:0]  out_beta;
  logic [6:0]  out_inv;
  logic [31:0] out_ssth;
  logic        out_last;

  // shared multiplier
  logic [39:0] mul_a;
  logic [31:0] mul_b;
  logic [71:0] prod;

  // shared divider
  logic                  div_start;
  logic [DIVIDEND_W-1:0] div_dividend;
  logic [DIVISOR_W-1:0]  div_divisor;
  logic [DIVIDEND_W-1:0] div_quo;
  div_stat_t             div_stat;

  logic        accept;
  logic        take_sample;
  logic [31:0] prior_gap;
  logic        round_end;
  logic [31:0] dm;
  logic [31:0] avg_fallback;
  logic [31:0] srtt_q;
  logic [7:0]  thresh;
  logic [7:0]  thresh_fl;
  logic [55:0] rule_b;
  logic [31:0] reduced;
  logic        out_free;

  dbbe_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid || m_axis_tready;
  assign prod     = {32'd0, mul_a} * {40'd0, mul_b};

  // sample accepted when in slow start or a clean positive sample, never negative
  assign take_sample = !in_rtt[31] && (in_ss || ((in_rtt != 32'd0) && !in_delayed));
  assign prior_gap   = in_prior - next_round_mark;
  assign round_end   = in_ivalid && !prior_gap[31];
  assign dm          = max_rtt - min_rtt;
  assign srtt_q      = {4'd0, in_srtt[31:4]};
  assign avg_fallback = (in_srtt > round_min_rtt) ? (in_srtt - round_min_rtt) :
                        ((srtt_q > 32'd1) ? srtt_q : 32'd1);
  assign thresh      = {lg, 1'b0};
  assign thresh_fl   = (thresh < win_floor) ? win_floor : thresh;
  assign rule_b      = prod[71:16];
  assign reduced     = in_cwnd - prod[37:6];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (kind_t'(s_axis_tuser))
            KIND_ACK:   state_next = ST_ACK;
            KIND_LOSS:  state_next = ST_LOSS;
            KIND_QUERY: state_next = ST_AVG;
            KIND_NONE:  state_next = ST_DONE;
          endcase
        end
      end
      ST_ACK:   state_next = ST_ROUND;
      ST_LOSS:  state_next = ST_DONE;
      ST_ROUND: begin
        if (round_end && (round_min_rtt != ALL_ONES)) state_next = ST_AVG;
        else state_next = ST_DONE;
      end
      ST_AVG: begin
        if (rtt_count != 32'd0) state_next = ST_AVG_WAIT;
        else if (in_kind == KIND_ACK) state_next = ST_RDIV;
        else state_next = ST_QMUL;
      end
      ST_AVG_WAIT: begin
        if (div_stat.done) state_next = (in_kind == KIND_ACK) ? ST_RDIV : ST_QMUL;
      end
      ST_RDIV:      state_next = ST_RDIV_WAIT;
      ST_RDIV_WAIT: if (div_stat.done) state_next = ST_PMUL;
      ST_PMUL:      state_next = ST_LOMUL;
      ST_LOMUL:     state_next = ST_HIMUL;
      ST_HIMUL:     state_next = ST_LOG;
      ST_LOG:       if (lg_step == 3'd6) state_next = ST_THRESH;
      ST_THRESH: begin
        if (in_cwnd < {24'd0, thresh_fl}) state_next = ST_CLOSE;
        else if (rtt_count != 32'd0) state_next = ST_D2;
        else state_next = ST_CLOSE;
      end
      ST_D2:  state_next = ST_D3;
      ST_D3:  state_next = ST_CMP;
      ST_CMP: begin
        if ((da <= d2) || (da >= d3)) state_next = ST_CLOSE;
        else state_next = ST_NUM;
      end
      ST_NUM:   state_next = ST_CLOSE;
      ST_CLOSE: state_next = ST_DONE;
      ST_QMUL:  state_next = ST_QDIV;
      ST_QDIV:  state_next = (q_div == 39'd0) ? ST_QRED : ST_QDIV_WAIT;
      ST_QDIV_WAIT: if (div_stat.done) state_next = ST_QRED;
      ST_QRED:  state_next = ST_DONE;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // unit controls: multiplier operands and divider requests
  always_comb begin
    mul_a        = '0;
    mul_b        = '0;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    unique case (state)
      ST_AVG: begin
        div_start    = (rtt_count != 32'd0);
        div_dividend = rtt_sum;
        div_divisor  = {8'd0, rtt_count};
      end
      ST_RDIV: begin
        div_start    = 1'b1;
        div_dividend = 64'h1_0000;
        div_divisor  = (in_seg == 16'd0) ? 40'd1 : {24'd0, in_seg};
      end
      ST_QDIV: begin
        div_start    = (q_div != 39'd0);
        div_dividend = {26'd0, current_rtt, 6'd0};
        div_divisor  = {1'b0, q_div};
      end
      ST_PMUL: begin
        mul_a = {8'd0, in_bw};
        mul_b = da;
      end
      ST_LOMUL: begin
        mul_a = {8'd0, bw_delay[31:0]};
        mul_b = {15'd0, recip_seg};
      end
      ST_HIMUL: begin
        mul_a = {8'd0, bw_delay[63:32]};
        mul_b = {15'd0, recip_seg};
      end
      ST_D2: begin
        mul_a = {8'd0, dm};
        mul_b = {16'd0, RECIP_TEN};
      end
      ST_D3: begin
        mul_a = {8'd0, dm};
        mul_b = {16'd0, RECIP_TEN8};
      end
      ST_NUM: begin
        mul_a = {2'd0, num};
        mul_b = {18'd0, RECIP_SEVEN};
      end
      ST_QMUL: begin
        mul_a = {8'd0, da};
        mul_b = {25'd0, 7'd64 - {1'b0, beta_reg}};
      end
      ST_QRED: begin
        mul_a = {8'd0, in_cwnd};
        mul_b = {26'd0, beta_reg};
      end
      default: ;
    endcase
  end

  // sequencer datapath and estimator state
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      out_valid        <= 1'b0;
      win_floor        <= WIN_FLOOR_RST;
      init_inv         <= INIT_INV_RST;
      base_inv         <= BASE_INV_RST;
      rtt_sum          <= '0;
      rtt_count        <= '0;
      last_sample      <= '0;
      round_min_rtt    <= ALL_ONES;
      round_max_rtt    <= '0;
      min_rtt          <= ALL_ONES;
      max_rtt          <= '0;
      current_rtt      <= '0;
      beta_reg         <= BETA_LO;
      inverse_beta_reg <= INIT_INV_RST;
      next_round_mark  <= '0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_WIN_FLOOR: win_floor <= cfg_data;
          CFG_INIT_INV:  init_inv  <= cfg_data[6:0];
          CFG_BASE_INV:  base_inv  <= cfg_data[6:0];
          CFG_UNUSED:    ;
        endcase
      end

      // the done state reloads the output register itself
      if (m_axis_tready && (state != ST_DONE)) out_valid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            in_kind    <= kind_t'(s_axis_tuser);
            in_rtt     <= s_axis_tdata[31:0];
            in_delayed <= s_axis_tdata[32];
            in_ss      <= s_axis_tdata[33];
            in_ivalid  <= s_axis_tdata[34];
            in_prior   <= s_axis_tdata[66:35];
            in_deliv   <= s_axis_tdata[98:67];
            in_srtt    <= s_axis_tdata[130:99];
            in_cwnd    <= s_axis_tdata[162:131];
            in_seg     <= s_axis_tdata[178:163];
            in_bw      <= s_axis_tdata[210:179];
            ssth       <= '0;
            ended      <= 1'b0;
          end
        end
        ST_ACK: begin
          if (take_sample) begin
            rtt_sum     <= rtt_sum + {32'd0, in_rtt};
            rtt_count   <= rtt_count + 32'd1;
            last_sample <= in_rtt;
            if (in_rtt < round_min_rtt) round_min_rtt <= in_rtt;
            if (in_rtt > round_max_rtt) round_max_rtt <= in_rtt;
          end
        end
        ST_LOSS: begin
          // withdraw the last sample and restart the round extremes
          if ((rtt_count != 32'd0) && (last_sample != 32'd0)) begin
            rtt_sum       <= rtt_sum - {32'd0, last_sample};
            rtt_count     <= rtt_count - 32'd1;
            round_min_rtt <= ALL_ONES;
            round_max_rtt <= '0;
          end
        end
        ST_ROUND: begin
          if (round_end) begin
            ended <= 1'b1;
            if (round_min_rtt != ALL_ONES) begin
              min_rtt <= round_min_rtt;
              max_rtt <= round_max_rtt;
            end else begin
              next_round_mark <= in_deliv;
            end
          end
        end
        ST_AVG: begin
          if (rtt_count == 32'd0) begin
            current_rtt <= in_srtt;
            da          <= avg_fallback;
          end
        end
        ST_AVG_WAIT: begin
          if (div_stat.done) begin
            current_rtt <= div_quo[31:0];
            da          <= div_quo[31:0] - min_rtt;
          end
        end
        ST_RDIV_WAIT: if (div_stat.done) recip_seg <= div_quo[16:0];
        ST_PMUL:  bw_delay <= prod[63:0];
        ST_LOMUL: lo_part  <= prod[48:0];
        ST_HIMUL: begin
          // bandwidth-delay over segment size, scaled down by 2^16
          lg_val  <= {16'd0, prod[48:0], 16'd0} + {48'd0, lo_part[48:16]};
          lg      <= '0;
          lg_step <= '0;
        end
        ST_LOG: begin
          // binary log2 search, halving the shift each step
          if ((lg_val >> (7'd64 >> lg_step)) != 81'd0) begin
            lg_val <= lg_val >> (7'd64 >> lg_step);
            lg     <= lg + (7'd64 >> lg_step);
          end
          lg_step <= lg_step + 3'd1;
        end
        ST_THRESH: begin
          if (in_cwnd < {24'd0, thresh_fl}) begin
            beta_reg         <= BETA_LO;
            inverse_beta_reg <= init_inv;
          end
        end
        ST_D2: d2 <= prod[47:16];
        ST_D3: d3 <= prod[47:16];
        ST_CMP: begin
          num <= {3'd0, d3, 3'd0} - {1'b0, d2, 5'd0} +
                 {2'd0, da, 4'd0} + {3'd0, da, 3'd0};
          if (da <= d2) begin
            beta_reg         <= BETA_LO;
            inverse_beta_reg <= inv_of(base_inv, BETA_LO);
          end else if (da >= d3) begin
            beta_reg         <= BETA_HI;
            inverse_beta_reg <= inv_of(base_inv, BETA_HI);
          end
        end
        ST_NUM: begin
          if (rule_b < {50'd0, BETA_LO}) begin
            beta_reg         <= BETA_LO;
            inverse_beta_reg <= inv_of(base_inv, BETA_LO);
          end else if (rule_b > {50'd0, BETA_HI}) begin
            beta_reg         <= BETA_HI;
            inverse_beta_reg <= inv_of(base_inv, BETA_HI);
          end else begin
            beta_reg         <= rule_b[5:0];
            inverse_beta_reg <= inv_of(base_inv, rule_b[5:0]);
          end
        end
        ST_CLOSE: begin
          rtt_sum         <= '0;
          rtt_count       <= '0;
          round_min_rtt   <= ALL_ONES;
          round_max_rtt   <= '0;
          next_round_mark <= in_deliv;
        end
        ST_QMUL: q_div <= prod[38:0];
        ST_QDIV: if (q_div == 39'd0) q_sat <= ALL_ONES;
        ST_QDIV_WAIT: begin
          if (div_stat.done) begin
            q_sat <= (div_quo[63:32] != 32'd0) ? ALL_ONES : div_quo[31:0];
          end
        end
        ST_QRED: begin
          if (q_sat < 32'd2) ssth <= (reduced > 32'd2) ? reduced : 32'd2;
          else ssth <= (q_sat > reduced) ? q_sat : reduced;
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_beta  <= beta_reg;
            out_inv   <= inverse_beta_reg;
            out_ssth  <= ssth;
            out_last  <= ended;
          end
        end
        default: ;
      endcase
    end
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'd0, out_ssth, out_inv, out_beta};
  assign m_axis_tlast  = out_last;

endmodule

// ----- rtl/core/dbbe_checker.sv -----
// ----------------------------------------------------------------------------
// dbbe_checker
// Port-level checks of the backoff estimator, bound to the top level.
// ----------------------------------------------------------------------------
module dbbe_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  input  logic                             s_axis_tready,
  input  logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic [dbbe_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input  logic                             m_axis_tlast
);
  import dbbe_pkg::*;

  // one item at a time: no accept right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while an item is in work");

  // beta always reported inside its clamp range
  a_beta_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ((m_axis_tdata[5:0] >= BETA_LO) && (m_axis_tdata[5:0] <= BETA_HI)))
    else $error("beta outside range");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("result word changed while stalled");

endmodule

bind delay_based_backoff_estimator_core dbbe_checker u_dbbe_checker (.*);

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the backoff estimator: random acks, losses and
// queries on the input stream, each result word compared with a predictor.
// ----------------------------------------------------------------------------
module tb;
  import dbbe_pkg::*;

  // one expected result word
  typedef struct {
    logic [5:0]  beta;
    logic [6:0]  inv;
    logic [31:0] ssth;
    logic        ended;
  } beta_word_t;

  // predictor of the estimator state plus the queue of expected words
  class backoff_board;
    logic [7:0]  win_floor;
    logic [6:0]  init_inv;
    logic [6:0]  base_inv;
    logic [63:0] rtt_sum;
    logic [31:0] rtt_cnt, prev_sample, rnd_min, rnd_max, min_rtt, max_rtt, cur_rtt, mark;
    logic [5:0]  beta;
    logic [6:0]  inv;
    beta_word_t  pending[$];
    int          errors;

    function void clear();
      win_floor = WIN_FLOOR_RST; init_inv = INIT_INV_RST; base_inv = BASE_INV_RST;
      rtt_sum = 0; rtt_cnt = 0; prev_sample = 0; rnd_min = ALL_ONES; rnd_max = 0;
      min_rtt = ALL_ONES; max_rtt = 0; cur_rtt = 0; beta = BETA_LO; inv = INIT_INV_RST;
      mark = 0; errors = 0; pending.delete();
    endfunction

    task report_mismatch(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    function void set_reg(cfg_idx_t idx, logic [7:0] v);
      case (idx)
        CFG_WIN_FLOOR: win_floor = v;
        CFG_INIT_INV:  init_inv = v[6:0];
        CFG_BASE_INV:  base_inv = v[6:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] mean_delay(logic [31:0] srtt);
      logic [63:0] t;
      if (rtt_cnt == 0) begin
        cur_rtt = srtt;
        if (srtt > rnd_min) return srtt - rnd_min;
        return (srtt >> 4) > 1 ? (srtt >> 4) : 32'd1;
      end
      t = rtt_sum / {32'd0, rtt_cnt};
      cur_rtt = t[31:0];
      return cur_rtt - min_rtt;
    endfunction

    function logic [5:0] pick_beta(logic [31:0] da, logic [31:0] dm);
      logic [63:0] d2, d3, num, b;
      d2 = ({32'd0, dm} * 64'd6554) >> 16;
      if ({32'd0, da} <= d2) return BETA_LO;
      d3 = ({32'd0, dm} * 64'd52432) >> 16;
      if ({32'd0, da} >= d3) return BETA_HI;
      num = 64'd8 * d3 - 64'd32 * d2 + 64'd24 * {32'd0, da};
      b = (num * 64'd9363) >> 16;
      if (b < 8) b = 8;
      if (b > 32) b = 32;
      return b[5:0];
    endfunction

    function void end_round(logic [215:0] d);
      logic [31:0]  da, lg, thr;
      logic [15:0]  seg;
      logic [127:0] p;
      da = mean_delay(d[130:99]);
      seg = d[178:163];
      if (seg == 0) seg = 1;
      // exact product: bandwidth * delay * (65536/seg) / 65536
      p = ({96'd0, d[210:179]} * {96'd0, da} * (128'd65536 / {112'd0, seg})) >> 16;
      lg = 0;
      for (int i = 1; i < 128; i++) if (p[i]) lg = i;
      thr = 2 * lg;
      if (thr < {24'd0, win_floor}) thr = {24'd0, win_floor};
      if (d[162:131] < thr) begin
        beta = BETA_LO; inv = init_inv;
      end else if (rtt_cnt > 0) begin
        beta = pick_beta(da, max_rtt - min_rtt);
        inv = (base_inv > {1'b0, beta}) ? base_inv - {1'b0, beta} : 7'd0;
      end
      rtt_sum = 0; rtt_cnt = 0;
    endfunction

    // note an accepted input word and queue what it should produce
    function void note_input(kind_t k, logic [215:0] d);
      beta_word_t  w;
      logic [31:0] raw, dl;
      logic [63:0] dv, q, cw, red;
      raw = d[31:0];
      w.ssth = 0; w.ended = 0;
      if (k == KIND_ACK) begin
        if ((d[33] || (raw != 0 && !d[32])) && !raw[31]) begin
          rtt_sum += {32'd0, raw}; rtt_cnt++; prev_sample = raw;
          if (raw < rnd_min) rnd_min = raw;
          if (raw > rnd_max) rnd_max = raw;
        end
        if (d[34] && (((d[66:35] - mark) & 32'h8000_0000) == 0)) begin
          if (rnd_min != ALL_ONES) begin
            min_rtt = rnd_min; max_rtt = rnd_max;
            end_round(d);
            rnd_min = ALL_ONES; rnd_max = 0;
          end
          mark = d[98:67];
          w.ended = 1;
        end
      end else if (k == KIND_LOSS) begin
        if (rtt_cnt > 0 && prev_sample > 0) begin
          rtt_sum -= {32'd0, prev_sample}; rtt_cnt--;
          rnd_min = ALL_ONES; rnd_max = 0;
        end
      end else if (k == KIND_QUERY) begin
        dl = mean_delay(d[130:99]);
        dv = {32'd0, dl} * (64'd64 - beta);
        q = (dv != 0) ? ({32'd0, cur_rtt} * 64'd64) / dv : {32'd0, ALL_ONES};
        cw = {32'd0, d[162:131]};
        red = cw - ((cw * beta) >> 6);
        if (q > {32'd0, ALL_ONES}) q = {32'd0, ALL_ONES};
        if (q < 2) q = 2;
        w.ssth = (q > red) ? q[31:0] : red[31:0];
      end
      w.beta = beta; w.inv = inv;
      pending.push_back(w);
    endfunction

    // compare a result word with the oldest expectation
    task check_result(logic [47:0] d, logic last);
      beta_word_t w;
      if (pending.size() == 0) begin
        report_mismatch("result word with nothing expected");
        return;
      end
      w = pending.pop_front();
      if (d[5:0] !== w.beta)
        report_mismatch($sformatf("beta %0d, want %0d", d[5:0], w.beta));
      if (d[12:6] !== w.inv)
        report_mismatch($sformatf("inverse beta %0d, want %0d", d[12:6], w.inv));
      if (d[44:13] !== w.ssth)
        report_mismatch($sformatf("ssthresh %0d, want %0d", d[44:13], w.ssth));
      if (last !== w.ended)
        report_mismatch($sformatf("round_ended %0b, want %0b", last, w.ended));
    endtask
  endclass

  logic                  clk = 0;
  logic                  rst = 1;
  logic                  s_axis_tvalid = 0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [1:0]            s_axis_tuser = KIND_ACK;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  cfg_we = 0;
  logic [1:0]            cfg_index = CFG_WIN_FLOOR;
  logic [7:0]            cfg_data = 0;

  backoff_board board;
  bit   hold_sink = 0;     // long receiver hold-off
  bit   sink_quiet = 0;    // stretch with no receiver idling
  bit   src_quiet = 0;
  logic [31:0] seq_mark;   // delivered count for well-formed rounds

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  delay_based_backoff_estimator_core dut (.*);

  // result side: random stalls, compares every accepted word
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      board.check_result(m_axis_tdata, m_axis_tlast);
  end

  initial begin
    int w;
    @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_sink) begin
        m_axis_tready <= 0;
      end else begin
        w = sink_quiet ? 0 : $urandom_range(0, 12);
        if (w == 0) begin
          m_axis_tready <= 1;
        end else begin
          m_axis_tready <= 0;
          repeat (w - 1) @(posedge clk);
        end
      end
    end
  end

  // valid stays up between back-to-back words; idle gaps drop it first
  task automatic send_word(kind_t k, logic [215:0] d);
    int w;
    w = src_quiet ? 0 : $urandom_range(0, 12);
    if (w != 0) begin
      s_axis_tvalid <= 0;
      repeat (w) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser  <= k;
    s_axis_tdata  <= d;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    board.note_input(k, d);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [7:0] v);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    board.set_reg(idx, v);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  // wait until every expected word is back, then let the core settle
  task automatic drain();
    s_axis_tvalid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic logic [215:0] pack_item(logic [31:0] rtt, bit dly, bit ss, bit iv,
      logic [31:0] prior, logic [31:0] now, logic [31:0] srtt, logic [31:0] cw,
      logic [15:0] seg, logic [31:0] bw);
    return {5'd0, bw, seg, cw, srtt, now, prior, iv, ss, dly, rtt};
  endfunction

  // random item; well-formed rounds dominate, with small rtt spread
  function automatic logic [215:0] rand_item(bit wild);
    logic [31:0] rtt, prior, now;
    if (wild) begin
      return pack_item($urandom, 1'($urandom), 1'($urandom), 1'($urandom), $urandom,
                       $urandom, $urandom, $urandom, 16'($urandom), $urandom);
    end
    rtt = ($urandom_range(0, 15) == 0) ? -$urandom_range(1, 100) : $urandom_range(100, 20000);
    prior = seq_mark + $urandom_range(0, 8) - 2;
    now = seq_mark + $urandom_range(1, 12);
    if ($urandom_range(0, 3) == 0) seq_mark = now;
    return pack_item(rtt, $urandom_range(0, 5) == 0, $urandom_range(0, 3) == 0,
                     $urandom_range(0, 7) != 0, prior, now, $urandom_range(0, 40000),
                     $urandom_range(0, 3) == 0 ? $urandom_range(0, 20) : $urandom_range(0, 2000),
                     16'($urandom_range(0, 9) == 0 ? $urandom : $urandom_range(500, 1500)),
                     $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 1 << 22));
  endfunction

  task automatic random_phase(int n);
    int   r;
    kind_t k;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      k = (r < 75) ? KIND_ACK : (r < 87) ? KIND_LOSS : (r < 97) ? KIND_QUERY : KIND_NONE;
      send_word(k, rand_item($urandom_range(0, 9) == 0));
    end
  endtask

  initial begin
    board = new();
    board.clear();
    seq_mark = 0;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes of the fields, every kind, zero segment size, zero divisor
    src_quiet = 1; sink_quiet = 1;
    send_word(KIND_QUERY, '0);
    send_word(KIND_LOSS, '0);
    send_word(KIND_ACK, pack_item(0, 0, 1, 1, 0, 10, 0, 0, 0, 0));
    send_word(KIND_ACK, pack_item(32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0, 0, 1, 0));
    send_word(KIND_ACK, pack_item(32'h8000_0000, 1, 1, 1, 10, 20, 0, ALL_ONES, 0, ALL_ONES));
    send_word(KIND_ACK, pack_item(1000, 0, 0, 0, 0, 0, 0, 0, 1000, 0));
    send_word(KIND_ACK, pack_item(5000, 0, 0, 0, 0, 0, 0, 0, 1000, 0));
    send_word(KIND_ACK, pack_item(3000, 1, 1, 1, 20, 40, 2000, 1000, 1000, 1 << 20));
    send_word(KIND_ACK, pack_item(1200, 0, 0, 0, 0, 0, 0, 0, 1000, 0));
    send_word(KIND_ACK, pack_item(4800, 0, 0, 0, 0, 0, 0, 0, 1000, 0));
    send_word(KIND_ACK, pack_item(900, 0, 0, 1, 40, 60, 0, ALL_ONES, 16'hFFFF, ALL_ONES));
    send_word(KIND_QUERY, pack_item(0, 0, 0, 0, 0, 0, ALL_ONES, ALL_ONES, 0, 0));
    send_word(KIND_ACK, pack_item(700, 1, 0, 0, 0, 0, 0, 0, 1, 0));
    send_word(KIND_ACK, pack_item(800, 0, 0, 0, 0, 0, 0, 0, 1, 0));
    send_word(KIND_LOSS, '0);
    send_word(KIND_LOSS, '0);
    send_word(KIND_LOSS, '0);
    send_word(KIND_QUERY, pack_item(0, 0, 0, 0, 0, 0, 500, 100, 1, 0));
    send_word(KIND_NONE, '1);
    send_word(KIND_ACK, pack_item(100, 0, 0, 1, ALL_ONES, 0, 50, 5, 1, 1));
    src_quiet = 0; sink_quiet = 0;
    drain();

    // long receiver hold-off while the sender keeps offering
    fork
      begin
        hold_sink = 1;
        repeat (3000) @(posedge clk);
        hold_sink = 0;
      end
      begin
        src_quiet = 1;
        random_phase(40);
        src_quiet = 0;
      end
    join
    drain();

    // settings, extremes included, each followed by a random phase
    write_reg(CFG_WIN_FLOOR, 8'd0);   write_reg(CFG_INIT_INV, 8'd0);
    write_reg(CFG_BASE_INV, 8'd32);   random_phase(400); drain();
    write_reg(CFG_WIN_FLOOR, 8'd255); write_reg(CFG_INIT_INV, 8'd127);
    write_reg(CFG_BASE_INV, 8'd127);  random_phase(300); drain();
    write_reg(CFG_WIN_FLOOR, 8'd4);   write_reg(CFG_INIT_INV, 8'd64);
    write_reg(CFG_BASE_INV, 8'd40);   write_reg(CFG_UNUSED, 8'hA5);
    sink_quiet = 1; random_phase(300); sink_quiet = 0; drain();
    write_reg(CFG_WIN_FLOOR, 8'd15);  write_reg(CFG_INIT_INV, 8'd80);
    write_reg(CFG_BASE_INV, 8'd88);   random_phase(650); drain();

    if (board.errors == 0 && board.pending.size() == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

  initial begin
    #20000000;
    $display("tb NOT OK");
    $finish;
  end
endmodule
